// ----- hdl/bfha_pkg.sv -----
// Shared types and constants for the best-fit heap allocator.
// Used by bfha_ctrl, bfha_dp and best_fit_heap_allocator_top; no dependencies.
package bfha_pkg;

  // block layout
  localparam logic [15:0] HDR_BYTES   = 16'd4;
  localparam logic [15:0] MIN_PAYLOAD = 16'd8;
  localparam logic [15:0] MIN_SPLIT   = 16'd12;
  localparam logic [31:0] MAX_REQ     = 32'h0000_FFFC;

  // parameter defaults
  localparam int DEF_POOL_BYTES   = 4096;
  localparam int DEF_FREE_ENTRIES = 256;

  // pool_bytes reset value
  localparam logic [12:0] POOL_RESET = 13'd4096;

  // action codes carried in tuser
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // one free-segment table entry
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // input transaction accepted
    logic seed;       // re-seed the heap
    logic check;      // screen request, read block size, init scan
    logic scan_run;   // walk the segment table
    logic apply;      // commit the decision
    logic move_run;   // shift table entries
    logic final_wr;   // write the inserted entry
    logic out_load;   // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic seed_pend;
    logic cfg_busy;
    logic reject;
    logic scan_done;
    logic move_done;
    logic final_pend;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/bfha_ctrl.sv -----
// Sequencing state machine of the best-fit heap allocator.
// Depends on bfha_pkg (cmd_t, sts_t); drives bfha_dp.
module bfha_ctrl import bfha_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SEED  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;
  localparam logic [2:0] ST_MOVE  = 3'd5;
  localparam logic [2:0] ST_FINAL = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state, state_next;

  assign s_tready = (state == ST_IDLE) && !sts.seed_pend && !sts.cfg_busy;

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.load     = s_tvalid && s_tready;
    case (state)
      ST_IDLE: begin
        if (sts.seed_pend && !sts.cfg_busy) state_next = ST_SEED;
        else if (s_tvalid && s_tready) state_next = ST_CHECK;
      end
      ST_SEED: begin
        cmd.seed   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.reject ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_MOVE;
      end
      ST_MOVE: begin
        cmd.move_run = 1'b1;
        if (sts.move_done) state_next = sts.final_pend ? ST_FINAL : ST_DONE;
      end
      ST_FINAL: begin
        cmd.final_wr = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

endmodule

// ----- hdl/bfha_dp.sv -----
// Datapath of the best-fit heap allocator: segment table, block size store,
// scan and shift logic, output register. Depends on bfha_pkg.
module bfha_dp import bfha_pkg::*; #(
  parameter int POOL_BYTES   = DEF_POOL_BYTES,
  parameter int FREE_ENTRIES = DEF_FREE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  input  logic [47:0] s_tdata,
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata
);

  localparam int AW = $clog2(FREE_ENTRIES);
  localparam int CW = $clog2(FREE_ENTRIES + 1);
  localparam int SD = POOL_BYTES / 4;
  localparam int SW = $clog2(SD);
  localparam logic [16:0]   PB17 = 17'(POOL_BYTES);
  localparam logic [16:0]   SD17 = 17'(SD);
  localparam logic [CW-1:0] FE_C = CW'(FREE_ENTRIES);
  localparam logic [CW-1:0] ONE  = CW'(1);

  // memories
  entry_t      tbl [FREE_ENTRIES];
  logic [15:0] store [SD];
  entry_t      rd_q;
  logic [15:0] st_q;

  // configuration and heap state
  logic [12:0]   pool_bytes, pool_eff;
  logic          seed_pend;
  logic [CW-1:0] count;

  // current transaction
  logic        act;
  logic [31:0] req;
  logic [15:0] off, want, h;

  // scan / move
  logic [CW-1:0] i, ev_i, best_i, idx, n;
  logic          rd_v, stop, found, prev_v, next_v, mv_left, final_pend;
  entry_t        best, prev, nxt;

  logic [15:0] res_off;
  logic        res_grant;

  // comb helpers
  logic [12:0] pool_eff_n;
  logic [15:0] h_n, want_n, want_r, rem, s1;
  logic        reject_n, iss, ev, mv_iss, t_prev, t_prev_next, t_h_next, dup;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  entry_t      wr_data;

  assign pool_eff_n = (17'(pool_bytes) > PB17) ? PB17[12:0] : pool_bytes;
  assign h_n        = off - HDR_BYTES;
  assign want_r     = (req[15:0] + 16'd3) & 16'hFFFC;
  assign want_n     = (want_r < MIN_PAYLOAD) ? MIN_PAYLOAD : want_r;

  // request screening
  always_comb begin
    if (act == ACT_ALLOC)
      reject_n = (count == '0) || (req == '0) || (req > MAX_REQ);
    else
      reject_n = (off == '0) || (off < HDR_BYTES) || (off[1:0] != 2'b00) ||
                 (h_n >= 16'(pool_eff)) || (17'(h_n[15:2]) >= SD17);
  end

  assign iss    = cmd.scan_run && !stop && (i < count);
  assign ev     = cmd.scan_run && rd_v && !stop;
  assign mv_iss = cmd.move_run && (n != '0);

  // merge arithmetic
  assign rem         = best.size - want;
  assign s1          = prev.size + HDR_BYTES + st_q;
  assign t_prev      = (18'(prev.start) + 18'd4 + 18'(prev.size)) == 18'(h);
  assign t_prev_next = (18'(prev.start) + 18'd4 + 18'(s1)) == 18'(nxt.start);
  assign t_h_next    = (18'(h) + 18'd4 + 18'(st_q)) == 18'(nxt.start);
  assign dup         = next_v && (nxt.start == h);

  // table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd.seed) begin
      wr_en   = pool_eff_n >= 13'(MIN_SPLIT);
      wr_data = '{start: 16'd0, size: 16'(pool_eff_n) - HDR_BYTES};
    end else if (cmd.apply) begin
      if (act == ACT_ALLOC) begin
        wr_en   = found && (rem >= MIN_SPLIT);
        wr_addr = best_i[AW-1:0];
        wr_data = '{start: best.start + HDR_BYTES + want, size: rem - HDR_BYTES};
      end else if (!dup) begin
        if (prev_v && t_prev) begin
          wr_en   = 1'b1;
          wr_addr = AW'(idx - ONE);
          wr_data = '{start: prev.start,
                      size: (next_v && t_prev_next) ? s1 + HDR_BYTES + nxt.size : s1};
        end else if (next_v && t_h_next) begin
          wr_en   = 1'b1;
          wr_addr = idx[AW-1:0];
          wr_data = '{start: h, size: st_q + HDR_BYTES + nxt.size};
        end
      end
    end else if (cmd.move_run && rd_v) begin
      wr_en   = 1'b1;
      wr_addr = mv_left ? AW'(ev_i - ONE) : AW'(ev_i + ONE);
      wr_data = rd_q;
    end else if (cmd.final_wr) begin
      wr_en   = 1'b1;
      wr_addr = idx[AW-1:0];
      wr_data = '{start: h, size: st_q};
    end
  end

  // segment table memory
  always_ff @(posedge clk) begin
    if (wr_en) tbl[wr_addr] <= wr_data;
    rd_q <= tbl[i[AW-1:0]];
  end

  // block size store
  always_ff @(posedge clk) begin
    if (cmd.apply && act == ACT_ALLOC && found && (17'(best.start[15:2]) < SD17))
      store[best.start[SW+1:2]] <= (rem >= MIN_SPLIT) ? want : best.size;
    if (cmd.check) st_q <= store[h_n[SW+1:2]];
  end

  // configuration and seeding
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_bytes <= POOL_RESET;
      seed_pend  <= 1'b1;
    end else if (cfg_we) begin
      pool_bytes <= cfg_wdata;
      seed_pend  <= 1'b1;
    end else if (cmd.seed) begin
      seed_pend  <= 1'b0;
    end
  end

  // transaction capture, scan, apply, move
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pool_eff   <= '0;
      rd_v       <= 1'b0;
      final_pend <= 1'b0;
      n          <= '0;
    end else begin
      if (cmd.seed) begin
        pool_eff <= pool_eff_n;
        count    <= (pool_eff_n >= 13'(MIN_SPLIT)) ? ONE : '0;
      end
      if (cmd.load) begin
        act <= s_tuser;
        req <= s_tdata[31:0];
        off <= s_tdata[47:32];
      end
      if (cmd.check) begin
        want      <= want_n;
        h         <= h_n;
        i         <= '0;
        rd_v      <= 1'b0;
        stop      <= 1'b0;
        found     <= 1'b0;
        prev_v    <= 1'b0;
        next_v    <= 1'b0;
        idx       <= count;
        res_off   <= '0;
        res_grant <= 1'b0;
      end
      // pipelined table walk: issue one read a cycle, evaluate the previous
      if (cmd.scan_run) begin
        rd_v <= iss;
        ev_i <= i;
        if (iss) i <= i + ONE;
        if (ev) begin
          if (act == ACT_ALLOC) begin
            if (rd_q.size >= want && (!found || rd_q.size < best.size)) begin
              found  <= 1'b1;
              best   <= rd_q;
              best_i <= ev_i;
            end
          end else if (rd_q.start >= h) begin
            idx    <= ev_i;
            nxt    <= rd_q;
            next_v <= 1'b1;
            stop   <= 1'b1;
          end else begin
            prev   <= rd_q;
            prev_v <= 1'b1;
          end
        end
      end
      if (cmd.apply) begin
        rd_v       <= 1'b0;
        final_pend <= 1'b0;
        n          <= '0;
        if (act == ACT_ALLOC) begin
          if (found) begin
            res_off   <= best.start + HDR_BYTES;
            res_grant <= 1'b1;
            if (rem < MIN_SPLIT) begin
              // remove the whole segment
              mv_left <= 1'b1;
              i       <= best_i + ONE;
              n       <= count - ONE - best_i;
              count   <= count - ONE;
            end
          end
        end else if (!dup) begin
          if (prev_v && t_prev) begin
            res_grant <= 1'b1;
            if (next_v && t_prev_next) begin
              mv_left <= 1'b1;
              i       <= idx + ONE;
              n       <= count - ONE - idx;
              count   <= count - ONE;
            end
          end else if (next_v && t_h_next) begin
            res_grant <= 1'b1;
          end else if (count < FE_C) begin
            // open a slot at idx
            res_grant  <= 1'b1;
            mv_left    <= 1'b0;
            i          <= count - ONE;
            n          <= count - idx;
            count      <= count + ONE;
            final_pend <= 1'b1;
          end
        end
      end
      if (cmd.move_run) begin
        rd_v <= mv_iss;
        ev_i <= i;
        if (mv_iss) begin
          i <= mv_left ? i + ONE : i - ONE;
          n <= n - ONE;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {7'd0, res_grant, res_off};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign sts.seed_pend  = seed_pend;
  assign sts.cfg_busy   = cfg_we;
  assign sts.reject     = reject_n;
  assign sts.scan_done  = stop || (!rd_v && !(i < count));
  assign sts.move_done  = (n == '0) && !rd_v;
  assign sts.final_pend = final_pend;
  assign sts.out_free   = !m_tvalid || m_tready;

  // table occupancy stays within its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FE_C)
    else $error("segment count beyond table depth");

  // a small pool seeds an empty heap
  a_seed_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.seed && (pool_eff_n < 13'(MIN_SPLIT)) |=> count == '0)
    else $error("small pool left segments in the table");

  // a granted allocate returns an aligned nonzero offset
  a_grant_off: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && res_grant && act == ACT_ALLOC |=>
      m_tdata[15:0] != 16'd0 && m_tdata[1:0] == 2'b00)
    else $error("granted allocate with bad offset");

endmodule

// ----- hdl/best_fit_heap_allocator_top.sv -----
// Best-fit heap allocator over a byte pool, one result per request: an allocate
// that passes screening scans the whole free-segment table and a free walks it
// up to the insertion point; removing a segment or opening a slot then shifts the
// table tail one entry a cycle. A new request is accepted only after the previous
// result is loaded into the output register; the segment table memory has a single
// read and write port. After reset and after each pool_bytes write, the input is
// held off while the heap is seeded.
// Depends on bfha_pkg, bfha_ctrl and bfha_dp.
module best_fit_heap_allocator_top import bfha_pkg::*; #(
  parameter int POOL_BYTES   = DEF_POOL_BYTES,
  parameter int FREE_ENTRIES = DEF_FREE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,   // pool_bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,     // request_bytes [31:0], free_offset [47:32]
  input  logic        s_tuser,     // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata      // payload_offset [15:0], granted [16], zero pad
);

  cmd_t cmd;
  sts_t sts;

  bfha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfha_dp #(
    .POOL_BYTES   (POOL_BYTES),
    .FREE_ENTRIES (FREE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- sim/best_fit_heap_allocator_top_test.sv -----
// Self-checking testbench for best_fit_heap_allocator_top: random and directed
// allocate/free transactions checked against an in-bench best-fit heap predictor.
// Depends on bfha_pkg and the allocator RTL.
`timescale 1ns / 1ps

module best_fit_heap_allocator_top_test;
  import bfha_pkg::*;

  localparam int POOL_MAX = DEF_POOL_BYTES;
  localparam int SEGS     = DEF_FREE_ENTRIES;
  localparam int BLK_SLOTS = POOL_MAX / 4;

  typedef struct packed {
    logic [15:0] offset;
    logic        ok;
  } grant_t;

  // scoreboard: heap predictor plus queue of expected grants
  class heap_scoreboard;
    int unsigned pool_eff;
    logic [15:0] seg_start [SEGS];
    logic [15:0] seg_size [SEGS];
    int unsigned seg_cnt;
    logic [15:0] blk_size [BLK_SLOTS];
    grant_t pending [$];
    int unsigned errors;
    int unsigned n_checked;

    function void reseed(int unsigned bytes);
      pool_eff = (bytes > POOL_MAX) ? POOL_MAX : bytes;
      seg_cnt = 0;
      if (pool_eff >= 12) begin
        seg_start[0] = 16'd0;
        seg_size[0] = 16'(pool_eff - 4);
        seg_cnt = 1;
      end
    endfunction

    function void clear_all();
      foreach (blk_size[i]) blk_size[i] = 16'd0;
      reseed(POOL_MAX);
    endfunction

    function void remove_seg(int unsigned idx);
      for (int unsigned i = idx; i + 1 < seg_cnt; i++) begin
        seg_start[i] = seg_start[i + 1];
        seg_size[i] = seg_size[i + 1];
      end
      if (seg_cnt > 0) seg_cnt--;
    endfunction

    function logic [15:0] carve(logic [31:0] req);
      int unsigned want, best, rem, st, sz;
      bit found;
      found = 0;
      best = 0;
      if (seg_cnt == 0 || req == 0 || req > MAX_REQ) return 16'd0;
      want = (req + 3) & ~32'd3;
      if (want < 8) want = 8;
      for (int unsigned i = 0; i < seg_cnt; i++) begin
        if (seg_size[i] < want) continue;
        if (!found || seg_size[i] < seg_size[best]) begin
          best = i;
          found = 1;
          if (seg_size[i] == want) break;
        end
      end
      if (!found) return 16'd0;
      st = seg_start[best];
      sz = seg_size[best];
      rem = sz - want;
      if (rem >= 12) begin
        seg_start[best] = 16'(st + 4 + want);
        seg_size[best] = 16'(rem - 4);
        sz = want;
      end else begin
        remove_seg(best);
      end
      if ((st >> 2) < BLK_SLOTS) blk_size[st >> 2] = 16'(sz);
      return 16'(st + 4);
    endfunction

    function bit release_blk(int unsigned off);
      int unsigned h, bsz, idx, cur;
      if (off < 4 || (off & 3) != 0) return 0;
      h = off - 4;
      if (h >= pool_eff || (h >> 2) >= BLK_SLOTS) return 0;
      bsz = blk_size[h >> 2];
      idx = 0;
      while (idx < seg_cnt && seg_start[idx] < h) idx++;
      if (idx < seg_cnt && seg_start[idx] == h) return 0;
      if (idx > 0 && seg_start[idx - 1] + 4 + seg_size[idx - 1] == h) begin
        cur = idx - 1;
        seg_size[cur] = 16'(seg_size[cur] + 4 + bsz);
      end else if (seg_cnt >= SEGS) begin
        if (idx < seg_cnt && h + 4 + bsz == seg_start[idx]) begin
          seg_size[idx] = 16'(bsz + 4 + seg_size[idx]);
          seg_start[idx] = 16'(h);
          return 1;
        end
        return 0;
      end else begin
        for (int unsigned i = seg_cnt; i > idx; i--) begin
          seg_start[i] = seg_start[i - 1];
          seg_size[i] = seg_size[i - 1];
        end
        seg_start[idx] = 16'(h);
        seg_size[idx] = 16'(bsz);
        seg_cnt++;
        cur = idx;
      end
      if (cur + 1 < seg_cnt &&
          seg_start[cur] + 4 + seg_size[cur] == seg_start[cur + 1]) begin
        seg_size[cur] = 16'(seg_size[cur] + 4 + seg_size[cur + 1]);
        remove_seg(cur + 1);
      end
      return 1;
    endfunction

    // note one accepted request; returns the predicted grant
    function grant_t note_request(logic act, logic [31:0] req, logic [15:0] off);
      grant_t g;
      if (act == ACT_ALLOC) begin
        g.offset = carve(req);
        g.ok = (g.offset != 0);
      end else begin
        g.offset = 16'd0;
        g.ok = (off != 0) && release_blk(off);
      end
      pending.push_back(g);
      return g;
    endfunction

    function void check_grant(logic [23:0] data);
      grant_t exp_g;
      n_checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", data);
        return;
      end
      exp_g = pending.pop_front();
      if (data[15:0] !== exp_g.offset || data[16] !== exp_g.ok || data[23:17] !== 7'd0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: exp off=%h ok=%b, got off=%h ok=%b pad=%h",
                   n_checked, exp_g.offset, exp_g.ok, data[15:0], data[16], data[23:17]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [12:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  heap_scoreboard sb;
  logic [15:0] live_offs [$];   // payload offsets currently allocated
  int unsigned stall_hold;      // receiver long hold-off request, in cycles
  bit bursty;                   // sender gaps enabled

  best_fit_heap_allocator_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  // receiver: stall pattern plus optional long hold-off
  initial begin
    int unsigned phase;
    phase = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready && !rst) sb.check_grant(m_tdata);
      if (stall_hold > 0) begin
        stall_hold--;
        m_tready <= 1'b0;
      end else begin
        phase++;
        if ((phase / 200) % 3 == 0) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // one request transaction; predictor updated at acceptance
  task automatic send_req(logic act, logic [31:0] req, logic [15:0] off);
    grant_t g;
    if (bursty && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {off, req};
    do @(posedge clk); while (!s_tready);
    g = sb.note_request(act, req, off);
    if (act == ACT_ALLOC && g.ok) live_offs.push_back(g.offset);
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic alloc_req(logic [31:0] req);
    send_req(ACT_ALLOC, req, 16'($urandom));
  endtask

  // free a randomly chosen live block
  task automatic free_live();
    int unsigned k;
    logic [15:0] off;
    if (live_offs.size() == 0) return;
    k = $urandom_range(0, live_offs.size() - 1);
    off = live_offs[k];
    live_offs.delete(k);
    send_req(ACT_FREE, $urandom, off);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // pool size write; stale block offsets are forgotten
  task automatic set_pool(logic [12:0] bytes);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.reseed(bytes);
    live_offs.delete();
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 9) == 0) alloc_req($urandom_range(200, 3000));
        else alloc_req($urandom_range(1, 64));
      end else if (r < 85) free_live();
      else if (r < 90) alloc_req($urandom);
      else if (r < 95) begin
        // misaligned or zero offset
        send_req(ACT_FREE, $urandom,
                 ($urandom_range(0, 1) != 0) ? (16'($urandom) | 16'h0001) : 16'd0);
      end else begin
        // double free / never-live lookalike of a free segment start
        if (sb.seg_cnt > 0)
          send_req(ACT_FREE, $urandom, sb.seg_start[$urandom_range(0, sb.seg_cnt - 1)] + 16'd4);
        else
          send_req(ACT_FREE, $urandom, 16'd0);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear_all();
    stall_hold = 0;
    bursty = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 13'd0;
    s_tvalid = 1'b0;
    s_tdata = 48'd0;
    s_tuser = ACT_ALLOC;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: size extremes, refusals, frees of odd offsets
    alloc_req(32'd0);
    alloc_req(32'hFFFF_FFFF);
    alloc_req(32'h0000_FFFD);
    alloc_req(32'h0000_FFFC);
    alloc_req(32'd1);
    alloc_req(32'd8);
    alloc_req(32'd13);
    alloc_req(32'd4000);
    alloc_req(32'd100);
    send_req(ACT_FREE, 32'd0, 16'd0);
    send_req(ACT_FREE, 32'd0, 16'd2);
    send_req(ACT_FREE, 32'd0, 16'd6);
    send_req(ACT_FREE, 32'd0, 16'hFFFC);
    send_req(ACT_FREE, 32'd0, 16'hFFFF);
    free_live();
    free_live();
    free_live();
    free_live();
    send_req(ACT_FREE, 32'd0, 16'd4);   // already free
    alloc_req(32'd4088);                // exact whole pool
    free_live();

    // tiny and boundary pools
    set_pool(13'd0);
    alloc_req(32'd4);
    set_pool(13'd11);
    alloc_req(32'd4);
    set_pool(13'd12);
    alloc_req(32'd8);
    alloc_req(32'd8);
    free_live();
    set_pool(13'h1FFF);   // saturates
    bursty = 1;
    random_phase(200);

    // fragmentation: many small blocks, free every other to fill the table
    set_pool(13'd4096);
    for (int i = 0; i < 300; i++) alloc_req(32'd8);
    for (int i = 0; i < live_offs.size(); i++) begin
      send_req(ACT_FREE, 32'd0, live_offs[i]);
      live_offs.delete(i);
    end
    // receiver holds off while sender keeps pushing
    stall_hold = 400;
    random_phase(200);
    drain();                   // sender waits for every result
    random_phase(250);

    set_pool(13'd256);
    random_phase(150);
    set_pool(13'd4096);
    bursty = 0;
    random_phase(150);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- best_fit_heap_allocator_top.f -----
hdl/bfha_pkg.sv
hdl/bfha_ctrl.sv
hdl/bfha_dp.sv
hdl/best_fit_heap_allocator_top.sv
sim/best_fit_heap_allocator_top_test.sv
